// ===== sv/psgfd_pkg.sv =====
// Package for the sound-chip parameter frame decoder.
// Holds field widths, controller and parameter codes and the state types.
// No dependencies; every other file of the block except psgfd_ram imports it.
package psgfd_pkg;

    localparam int CHANNEL_W     = 5;
    localparam int CTRL_W        = 7;
    localparam int PARAM_INDEX_W = 5;
    localparam int PARAM_VALUE_W = 14;

    // Controller numbers that the decoder reacts to.
    localparam logic [CTRL_W-1:0] CC_BREATH = 7'd2;
    localparam logic [CTRL_W-1:0] CC_VOLUME = 7'd7;
    localparam logic [CTRL_W-1:0] CC_COARSE = 7'd20;
    localparam logic [CTRL_W-1:0] CC_FINE   = 7'd52;
    localparam logic [CTRL_W-1:0] CC_SHAPE  = 7'd70;
    localparam logic [CTRL_W-1:0] CC_GPB1   = 7'd80;
    localparam logic [CTRL_W-1:0] CC_GPB2   = 7'd81;
    localparam logic [CTRL_W-1:0] CC_GPB3   = 7'd82;
    localparam logic [CTRL_W-1:0] CC_GPB4   = 7'd83;

    // First parameter index of each group.
    localparam logic [PARAM_INDEX_W-1:0] P_VOLUME       = 5'd0;
    localparam logic [PARAM_INDEX_W-1:0] P_TONE_PERIOD  = 5'd3;
    localparam logic [PARAM_INDEX_W-1:0] P_TONE_ON      = 5'd6;
    localparam logic [PARAM_INDEX_W-1:0] P_NOISE_ON     = 5'd9;
    localparam logic [PARAM_INDEX_W-1:0] P_ENV_ON       = 5'd12;
    localparam logic [PARAM_INDEX_W-1:0] P_RETRIG       = 5'd15;
    localparam logic [PARAM_INDEX_W-1:0] P_NOISE_PERIOD = 5'd18;
    localparam logic [PARAM_INDEX_W-1:0] P_ENV_PERIOD   = 5'd19;
    localparam logic [PARAM_INDEX_W-1:0] P_ENV_SHAPE    = 5'd20;

    // Channel offset of the noise and envelope channel.
    localparam logic [1:0] NOISE_ENV_SLOT = 2'd3;

    // Low seven bits hold the fine part of a period, the upper seven the coarse part.
    localparam logic [PARAM_VALUE_W-1:0] FINE_MASK   = 14'h007F;
    localparam logic [PARAM_VALUE_W-1:0] COARSE_MASK = 14'h3F80;
    localparam int                       COARSE_SHIFT = 7;

    localparam logic [CHANNEL_W-1:0] BASE_CHANNEL_RESET = 5'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPD_RD,
        ST_UPD_WR
    } state_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_PUT,
        UPD_COARSE,
        UPD_FINE
    } upd_kind_t;

endpackage

// ===== sv/psgfd_midi_if.sv =====
// Valid/ready channel that carries one decoded MIDI message per transfer.
// Depends on psgfd_pkg for the field widths.
interface psgfd_midi_if #(
    parameter int TIME_BITS = 32
);
    import psgfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [TIME_BITS-1:0]     time_stamp;
    logic [CHANNEL_W-1:0]     midi_channel;
    logic [CTRL_W-1:0]        controller_number;
    logic [CTRL_W-1:0]        controller_value;

    modport source (
        output valid, command, time_stamp, midi_channel,
               controller_number, controller_value,
        input  ready
    );

    modport sink (
        input  valid, command, time_stamp, midi_channel,
               controller_number, controller_value,
        output ready
    );
endinterface

// ===== sv/psgfd_param_if.sv =====
// Valid/ready channel that carries one frame parameter per transfer.
// Depends on psgfd_pkg for the field widths.
interface psgfd_param_if;
    import psgfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [PARAM_INDEX_W-1:0] param_index;
    logic [PARAM_VALUE_W-1:0] param_value;
    logic                     last;

    modport source (
        output valid, param_index, param_value, last,
        input  ready
    );

    modport sink (
        input  valid, param_index, param_value, last,
        output ready
    );
endinterface

// ===== sv/psgfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module psgfd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 21
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== sv/psg_param_midi_frame_decoder_core.sv =====
// Sound-chip parameter frame decoder. A message whose time stamp is later than the
// previous one flushes the open frame: the parameters that were set are sent in
// ascending index order, the last one marked, and the frame is cleared. A control
// change on one of the four channels from base_channel then updates one parameter.
// The values live in a RAM with one read port; set flags are flip-flops, so reset
// needs no clearing pass. A message that does not flush goes through a RAM read and a
// write of the updated value (the write is skipped when it changes nothing); a flushing
// message first scans the parameter slots, one slot per cycle through the RAM read port
// unless the frame sink stalls, then drains the last slot before the update.
module psg_param_midi_frame_decoder_core #(
    parameter int NUM_PARAMS = 21,
    parameter int TIME_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         base_channel_we,
    input  logic [psgfd_pkg::CHANNEL_W-1:0] base_channel_wdata,
    psgfd_midi_if.sink                   midi,
    psgfd_param_if.source                frame
);
    import psgfd_pkg::*;

    localparam int IDX_W = $clog2(NUM_PARAMS);

    // Control state.
    state_t                    state_reg, state_next;
    logic [CHANNEL_W-1:0]      base_channel_reg, base_channel_next;
    logic [TIME_BITS-1:0]      prev_ts_reg, prev_ts_next;
    logic [NUM_PARAMS-1:0]     flags_reg, flags_next;
    logic [IDX_W-1:0]          scan_idx_reg, scan_idx_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic                      out_valid_reg, out_valid_next;

    // Payload.
    logic                      cmd_reg, cmd_next;
    logic [CHANNEL_W-1:0]      chan_reg, chan_next;
    logic [CTRL_W-1:0]         ctrl_reg, ctrl_next;
    logic [CTRL_W-1:0]         val_reg, val_next;
    logic [IDX_W-1:0]          pend_idx_reg, pend_idx_next;
    logic                      pend_last_reg, pend_last_next;
    logic [PARAM_INDEX_W-1:0]  out_idx_reg, out_idx_next;
    logic [PARAM_VALUE_W-1:0]  out_value_reg, out_value_next;
    logic                      out_last_reg, out_last_next;

    // RAM port signals.
    logic                      ram_re;
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_raddr;
    logic [PARAM_VALUE_W-1:0]  ram_wdata;
    logic [PARAM_VALUE_W-1:0]  ram_rdata;

    // Decode of the latched message.
    logic [CHANNEL_W:0]        chan_ext;
    logic [CHANNEL_W:0]        base_ext;
    logic [CHANNEL_W:0]        chan_off;
    logic                      in_window;
    logic [1:0]                slot;
    upd_kind_t                 upd_kind;
    logic [IDX_W-1:0]          upd_idx;
    logic [PARAM_VALUE_W-1:0]  old_value;
    logic [PARAM_VALUE_W-1:0]  val_ext;

    logic                      in_xfer;
    logic                      flush;
    logic                      out_load;
    logic                      scan_go;
    logic                      scan_end;
    logic [NUM_PARAMS-1:0]     flags_from_idx;

    psgfd_ram #(
        .WIDTH (PARAM_VALUE_W),
        .DEPTH (NUM_PARAMS)
    ) u_values (
        .clk   (clk),
        .we    (ram_we),
        .waddr (upd_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_xfer = midi.valid && midi.ready;
    assign flush   = midi.time_stamp > prev_ts_reg;

    // The frame register takes the pending slot once the RAM data for it is out.
    assign out_load = pend_valid_reg && (!out_valid_reg || frame.ready);
    assign scan_go  = (state_reg == ST_SCAN) && (!pend_valid_reg || out_load);
    assign scan_end = scan_go && (scan_idx_reg == IDX_W'(NUM_PARAMS - 1));
    assign flags_from_idx = flags_reg >> scan_idx_reg;

    // Channel window compared at full width without wrap.
    always_comb
    begin
        chan_ext  = {1'b0, chan_reg};
        base_ext  = {1'b0, base_channel_reg};
        chan_off  = chan_ext - base_ext;
        in_window = cmd_reg && (chan_ext >= base_ext)
                    && (chan_ext < base_ext + (CHANNEL_W+1)'(4));
        slot      = chan_off[1:0];
    end

    always_comb
    begin
        upd_kind = UPD_NONE;
        upd_idx  = IDX_W'(P_VOLUME);
        if (in_window)
        begin
            if (slot == NOISE_ENV_SLOT)
            begin
                case (ctrl_reg)
                    CC_COARSE:
                    begin
                        upd_kind = UPD_COARSE;
                        upd_idx  = IDX_W'(P_ENV_PERIOD);
                    end
                    CC_FINE:
                    begin
                        upd_kind = UPD_FINE;
                        upd_idx  = IDX_W'(P_ENV_PERIOD);
                    end
                    CC_BREATH:
                    begin
                        upd_kind = UPD_PUT;
                        upd_idx  = IDX_W'(P_NOISE_PERIOD);
                    end
                    CC_SHAPE:
                    begin
                        upd_kind = UPD_PUT;
                        upd_idx  = IDX_W'(P_ENV_SHAPE);
                    end
                    default:
                    begin
                        upd_kind = UPD_NONE;
                    end
                endcase
            end
            else
            begin
                case (ctrl_reg)
                    CC_VOLUME:
                    begin
                        upd_kind = UPD_PUT;
                        upd_idx  = IDX_W'(P_VOLUME) + IDX_W'(slot);
                    end
                    CC_COARSE:
                    begin
                        upd_kind = UPD_COARSE;
                        upd_idx  = IDX_W'(P_TONE_PERIOD) + IDX_W'(slot);
                    end
                    CC_FINE:
                    begin
                        upd_kind = UPD_FINE;
                        upd_idx  = IDX_W'(P_TONE_PERIOD) + IDX_W'(slot);
                    end
                    CC_GPB1:
                    begin
                        upd_kind = UPD_PUT;
                        upd_idx  = IDX_W'(P_TONE_ON) + IDX_W'(slot);
                    end
                    CC_GPB2:
                    begin
                        upd_kind = UPD_PUT;
                        upd_idx  = IDX_W'(P_NOISE_ON) + IDX_W'(slot);
                    end
                    CC_GPB3:
                    begin
                        upd_kind = UPD_PUT;
                        upd_idx  = IDX_W'(P_ENV_ON) + IDX_W'(slot);
                    end
                    CC_GPB4:
                    begin
                        upd_kind = UPD_PUT;
                        upd_idx  = IDX_W'(P_RETRIG) + IDX_W'(slot);
                    end
                    default:
                    begin
                        upd_kind = UPD_NONE;
                    end
                endcase
            end
        end
    end

    // An entry whose flag is clear reads as zero, whatever the RAM holds.
    always_comb
    begin
        old_value = flags_reg[upd_idx] ? ram_rdata : '0;
        val_ext   = PARAM_VALUE_W'(val_reg);
        case (upd_kind)
            UPD_COARSE: ram_wdata = (old_value & FINE_MASK)
                                    | ((val_ext << COARSE_SHIFT) & COARSE_MASK);
            UPD_FINE:   ram_wdata = (old_value & COARSE_MASK) | val_ext;
            default:    ram_wdata = val_ext;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = flush ? ST_SCAN : ST_UPD_RD;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_UPD_RD:
            begin
                state_next = (upd_kind == UPD_NONE) ? ST_IDLE : ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        midi.ready = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = upd_idx;
        unique case (state_reg)
            ST_IDLE:
            begin
                midi.ready = 1'b1;
            end
            ST_SCAN:
            begin
                ram_raddr = scan_idx_reg;
                ram_re    = scan_go && flags_reg[scan_idx_reg];
            end
            ST_DRAIN:
            begin
                ram_re = 1'b0;
            end
            ST_UPD_RD:
            begin
                ram_re = (upd_kind != UPD_NONE);
            end
            ST_UPD_WR:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                midi.ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        base_channel_next = base_channel_reg;
        prev_ts_next      = prev_ts_reg;
        flags_next        = flags_reg;
        scan_idx_next     = scan_idx_reg;
        pend_valid_next   = pend_valid_reg;
        pend_idx_next     = pend_idx_reg;
        pend_last_next    = pend_last_reg;
        out_valid_next    = out_valid_reg;
        out_idx_next      = out_idx_reg;
        out_value_next    = out_value_reg;
        out_last_next     = out_last_reg;
        cmd_next          = cmd_reg;
        chan_next         = chan_reg;
        ctrl_next         = ctrl_reg;
        val_next          = val_reg;

        if (base_channel_we)
        begin
            base_channel_next = base_channel_wdata;
        end

        if (in_xfer)
        begin
            prev_ts_next  = midi.time_stamp;
            cmd_next      = midi.command;
            chan_next     = midi.midi_channel;
            ctrl_next     = midi.controller_number;
            val_next      = midi.controller_value;
            scan_idx_next = '0;
        end

        // Frame register: a transfer empties it, a pending slot refills it.
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = PARAM_INDEX_W'(pend_idx_reg);
            out_value_next = ram_rdata;
            out_last_next  = pend_last_reg;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (scan_go)
        begin
            pend_valid_next = flags_reg[scan_idx_reg];
            pend_idx_next   = scan_idx_reg;
            // The slot is the last of the frame when no higher flag is set.
            pend_last_next  = (flags_from_idx >> 1) == '0;
            scan_idx_next   = scan_idx_reg + IDX_W'(1);
        end
        else if (out_load)
        begin
            pend_valid_next = 1'b0;
        end

        if (scan_end)
        begin
            flags_next = '0;
        end
        else if (state_reg == ST_UPD_WR)
        begin
            flags_next[upd_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            base_channel_reg <= BASE_CHANNEL_RESET;
            prev_ts_reg      <= '0;
            flags_reg        <= '0;
            scan_idx_reg     <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            base_channel_reg <= base_channel_next;
            prev_ts_reg      <= prev_ts_next;
            flags_reg        <= flags_next;
            scan_idx_reg     <= scan_idx_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        chan_reg      <= chan_next;
        ctrl_reg      <= ctrl_next;
        val_reg       <= val_next;
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        out_idx_reg   <= out_idx_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign frame.valid       = out_valid_reg;
    assign frame.param_index = out_idx_reg;
    assign frame.param_value = out_value_reg;
    assign frame.last        = out_last_reg;

endmodule

// ===== sv/psgfd_checker.sv =====
// Port-level checks for the parameter frame decoder, bound to its top level.
// Depends on psgfd_pkg and on psg_param_midi_frame_decoder_core.
module psgfd_checker #(
    parameter int NUM_PARAMS = 21
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                midi_valid,
    input logic                                midi_ready,
    input logic                                frame_valid,
    input logic                                frame_ready,
    input logic [psgfd_pkg::PARAM_INDEX_W-1:0] frame_param_index,
    input logic [psgfd_pkg::PARAM_VALUE_W-1:0] frame_param_value,
    input logic                                frame_last
);
    import psgfd_pkg::*;

    logic                     in_frame_reg;
    logic [PARAM_INDEX_W-1:0] prev_idx_reg;
    logic                     frame_xfer;

    assign frame_xfer = frame_valid && frame_ready;

    // Tracks whether a frame is partly sent and which index went last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            prev_idx_reg <= '0;
        end
        else if (frame_xfer)
        begin
            in_frame_reg <= !frame_last;
            prev_idx_reg <= frame_param_index;
        end
    end

    // A stalled parameter stays put.
    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid
        && $stable(frame_param_index) && $stable(frame_param_value) && $stable(frame_last))
        else $error("frame payload changed while stalled");

    // One extra bit keeps a full 32-entry store comparable.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> {1'b0, frame_param_index} < (PARAM_INDEX_W+1)'(NUM_PARAMS))
        else $error("parameter index out of range");

    // Within one frame the indices strictly rise.
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        frame_xfer && in_frame_reg |-> frame_param_index > prev_idx_reg)
        else $error("frame parameters out of order");

    // One message is worked on at a time.
    a_one_message: assert property (@(posedge clk) disable iff (!rst_n)
        midi_valid && midi_ready |=> !midi_ready)
        else $error("second message taken while busy");

endmodule

bind psg_param_midi_frame_decoder_core psgfd_checker #(
    .NUM_PARAMS (NUM_PARAMS)
) u_psgfd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .midi_valid        (midi.valid),
    .midi_ready        (midi.ready),
    .frame_valid       (frame.valid),
    .frame_ready       (frame.ready),
    .frame_param_index (frame.param_index),
    .frame_param_value (frame.param_value),
    .frame_last        (frame.last)
);
